// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Clock i_clk and active-low synchronous reset i_rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ===== design/mcr_pkg.sv =====
// Shared types, constants and the midpoint iteration for the circle rasterizer.
// No dependencies.
package mcr_pkg;

    localparam int CoordW  = 12;  // center coordinate
    localparam int PixW    = 13;  // emitted point coordinate
    localparam int RadW    = 10;  // radius / offsets
    localparam int DecW    = 13;  // decision variable
    localparam int FrameW  = 11;  // frame size registers
    localparam int AddrW   = 20;
    localparam int ColorW  = 32;
    localparam int IdxW    = 3;   // up to eight results per item

    localparam logic [FrameW-1:0] FRAME_RESET = 11'd400;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // kind of the item being emitted
    typedef enum logic [1:0] {
        KIND_START,
        KIND_STEP,
        KIND_END
    } t_kind;

    localparam logic [IdxW-1:0] LAST_START = 3'd3;
    localparam logic [IdxW-1:0] LAST_STEP  = 3'd7;
    localparam logic [IdxW-1:0] LAST_END   = 3'd0;

    typedef struct packed {
        logic               emit;
        logic [RadW-1:0]    maj;
        logic [RadW-1:0]    mnr;
        logic [DecW-1:0]    dec;
    } t_adv;

    typedef struct packed {
        logic [PixW-1:0]    x;
        logic [PixW-1:0]    y;
        logic               valid;
        logic [AddrW-1:0]   addr;
    } t_point;

    // One midpoint iteration; emit is low on overshoot.
    function automatic t_adv advance(input logic [RadW-1:0] maj,
                                     input logic [RadW-1:0] mnr,
                                     input logic [DecW-1:0] dec);
        t_adv            r;
        logic [RadW-1:0] m1;
        logic [RadW-1:0] j1;
        logic [DecW-1:0] d1;
        m1 = mnr + 1'b1;
        j1 = maj;
        d1 = dec + {2'b00, m1, 1'b1};
        if ($signed(d1) > 0) begin
            j1 = maj - 1'b1;
            d1 = d1 - {2'b00, j1, 1'b0};
        end
        r.emit = (maj > mnr) && (j1 >= m1);
        r.maj  = j1;
        r.mnr  = m1;
        r.dec  = d1;
        return r;
    endfunction

    function automatic logic [IdxW-1:0] last_idx(input t_kind kind);
        logic [IdxW-1:0] r;
        case (kind)
            KIND_START: r = LAST_START;
            KIND_STEP:  r = LAST_STEP;
            default:    r = LAST_END;
        endcase
        return r;
    endfunction

endpackage

// ===== design/mcr_point.sv =====
// Point generator: picks one of the symmetric points, clips it, forms its address.
// Depends on mcr_pkg.
module mcr_point (
    input  mcr_pkg::t_kind                  i_kind,
    input  logic [mcr_pkg::IdxW-1:0]        i_idx,
    input  logic [mcr_pkg::CoordW-1:0]      i_cx,
    input  logic [mcr_pkg::CoordW-1:0]      i_cy,
    input  logic [mcr_pkg::RadW-1:0]        i_maj,
    input  logic [mcr_pkg::RadW-1:0]        i_mnr,
    input  logic [mcr_pkg::FrameW-1:0]      i_frame_w,
    input  logic [mcr_pkg::FrameW-1:0]      i_frame_h,
    output mcr_pkg::t_point                 o_point
);

    logic [mcr_pkg::IdxW-1:0]   k;      // {swap, neg x, neg y}
    logic [mcr_pkg::RadW-1:0]   a;
    logic [mcr_pkg::RadW-1:0]   b;
    logic [mcr_pkg::PixW-1:0]   ax;
    logic [mcr_pkg::PixW-1:0]   by;
    logic [mcr_pkg::PixW-1:0]   px;
    logic [mcr_pkg::PixW-1:0]   py;
    logic                       in_x;
    logic                       in_y;
    logic [22:0]                lin;

    always_comb begin
        // start walks the axis points: +x, -x, +y, -y
        case (i_kind)
            mcr_pkg::KIND_START: k = {i_idx[1], i_idx[0] & ~i_idx[1], i_idx[0] & i_idx[1]};
            default:             k = i_idx;
        endcase
        a  = k[2] ? i_mnr : i_maj;
        b  = k[2] ? i_maj : i_mnr;
        ax = k[1] ? (13'd0 - {3'b000, a}) : {3'b000, a};
        by = k[0] ? (13'd0 - {3'b000, b}) : {3'b000, b};
        if (i_kind == mcr_pkg::KIND_END) begin
            px = '0;
            py = '0;
        end else begin
            px = {i_cx[mcr_pkg::CoordW-1], i_cx} + ax;
            py = {i_cy[mcr_pkg::CoordW-1], i_cy} + by;
        end
        in_x = !px[mcr_pkg::PixW-1] && ({1'b0, px[11:0]} < {2'b00, i_frame_w});
        in_y = !py[mcr_pkg::PixW-1] && ({1'b0, py[11:0]} < {2'b00, i_frame_h});
        // full-width product; the address is cut to 20 bits afterwards
        lin  = ({12'd0, i_frame_w} * {11'd0, py[11:0]}) + {11'd0, px[11:0]};
        o_point.x     = px;
        o_point.y     = py;
        o_point.valid = in_x && in_y && (i_kind != mcr_pkg::KIND_END);
        o_point.addr  = o_point.valid ? lin[mcr_pkg::AddrW-1:0] : '0;
    end

endmodule

// ===== design/midpoint_circle_rasterizer_core.sv =====
// Midpoint circle rasterizer core: command register, iteration state, point emitter.
// Depends on mcr_pkg, mcr_point and assert_macros.svh.
//
//  channel   direction   handshake                   payload
//  -------   ---------   -------------------------   ----------------------------------------
//  in        sink        i_in_valid / o_in_stall     i_command, i_center_x/y, i_radius, i_color
//  out       source      o_out_valid / i_out_stall   o_pixel_*, o_circle_done, o_last_of_run
//  cfg       sink        i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One result per cycle unless the output stalls: a start gives 4 results, a step 8, an
// overshoot step 1; the output register is the bottleneck. The next command is taken
// in the cycle the previous command's last result enters the output register, so runs
// chain gaplessly. The command is registered in the circle state before its first result.
// Synchronous active-low reset clears the circle state and sets both frame sizes to 400.
// A stalled output holds; emission pauses and, during a run, the input stalls until it drains.
module midpoint_circle_rasterizer_core #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic signed [11:0]              i_center_x,
    input  logic signed [11:0]              i_center_y,
    input  logic [9:0]                      i_radius,
    input  logic [31:0]                     i_color,
    // point channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [12:0]              o_pixel_x,
    output logic signed [12:0]              o_pixel_y,
    output logic                            o_pixel_valid,
    output logic [19:0]                     o_pixel_address,
    output logic [31:0]                     o_pixel_color,
    output logic                            o_circle_done,
    output logic                            o_last_of_run,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [10:0]                     i_cfg_data
);

    // frame size
    logic [mcr_pkg::FrameW-1:0]     r_frame_w;
    logic [mcr_pkg::FrameW-1:0]     r_frame_h;
    logic [mcr_pkg::FrameW-1:0]     cfg_clamped;

    // circle state; also serves as the snapshot of the item being emitted
    logic [mcr_pkg::RadW-1:0]       r_maj;
    logic [mcr_pkg::RadW-1:0]       r_mnr;
    logic [mcr_pkg::DecW-1:0]       r_dec;
    logic [mcr_pkg::CoordW-1:0]     r_ccol;
    logic [mcr_pkg::CoordW-1:0]     r_crow;
    logic [mcr_pkg::ColorW-1:0]     r_color;
    logic                           r_active;

    // emitter
    mcr_pkg::t_kind                 r_kind;
    logic [mcr_pkg::IdxW-1:0]       r_idx;
    logic                           r_busy;

    // output register
    logic                           r_out_valid;
    logic [mcr_pkg::PixW-1:0]       r_px;
    logic [mcr_pkg::PixW-1:0]       r_py;
    logic                           r_pvalid;
    logic [mcr_pkg::AddrW-1:0]      r_addr;
    logic [mcr_pkg::ColorW-1:0]     r_pcolor;
    logic                           r_done;
    logic                           r_last;

    mcr_pkg::t_adv                  adv_now;   // iteration from current state
    mcr_pkg::t_point                point;
    logic                           out_free;
    logic                           emit_fire;
    logic                           item_last;
    logic                           in_fire;
    logic                           done_now;

    assign adv_now   = mcr_pkg::advance(r_maj, r_mnr, r_dec);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = r_busy && out_free;
    assign item_last = (r_idx == mcr_pkg::last_idx(r_kind));
    assign o_in_stall = r_busy && !(emit_fire && item_last);
    assign in_fire   = i_in_valid && !o_in_stall;
    // the state holds the item being emitted: done means the next
    // iteration would overshoot, or the item is the overshoot result
    assign done_now  = (r_kind == mcr_pkg::KIND_END) || !adv_now.emit;

    assign o_cfg_ready = 1'b1;
    assign cfg_clamped = (int'(i_cfg_data) > MAX_FRAME) ? mcr_pkg::FrameW'(MAX_FRAME)
                                                        : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= mcr_pkg::FRAME_RESET;
            r_frame_h <= mcr_pkg::FRAME_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcr_pkg::CFG_FRAME_WIDTH:  r_frame_w <= cfg_clamped;
                mcr_pkg::CFG_FRAME_HEIGHT: r_frame_h <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // command intake and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maj    <= '0;
            r_mnr    <= '0;
            r_dec    <= '0;
            r_ccol   <= '0;
            r_crow   <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
            r_kind   <= mcr_pkg::KIND_END;
            r_idx    <= '0;
            r_busy   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                if (i_command == mcr_pkg::CMD_START) begin
                    r_kind   <= mcr_pkg::KIND_START;
                    r_ccol   <= i_center_x;
                    r_crow   <= i_center_y;
                    r_maj    <= i_radius;
                    r_mnr    <= '0;
                    r_dec    <= 13'd1 - {3'b000, i_radius};
                    r_color  <= i_color;
                    r_active <= 1'b1;
                end else if (r_active && adv_now.emit) begin
                    r_kind <= mcr_pkg::KIND_STEP;
                    r_maj  <= adv_now.maj;
                    r_mnr  <= adv_now.mnr;
                    r_dec  <= adv_now.dec;
                end else begin
                    // overshoot or nothing in progress
                    r_kind   <= mcr_pkg::KIND_END;
                    r_active <= 1'b0;
                end
            end else if (emit_fire) begin
                if (item_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    mcr_point u_point (
        .i_kind    (r_kind),
        .i_idx     (r_idx),
        .i_cx      (r_ccol),
        .i_cy      (r_crow),
        .i_maj     (r_maj),
        .i_mnr     (r_mnr),
        .i_frame_w (r_frame_w),
        .i_frame_h (r_frame_h),
        .o_point   (point)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_px     <= point.x;
            r_py     <= point.y;
            r_pvalid <= point.valid;
            r_addr   <= point.addr;
            r_pcolor <= r_color;
            r_done   <= done_now;
            r_last   <= item_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_valid   = r_pvalid;
    assign o_pixel_address = r_addr;
    assign o_pixel_color   = r_pcolor;
    assign o_circle_done   = r_done;
    assign o_last_of_run   = r_last;

`include "assert_macros.svh"

    `ASSERT_CLK(a_idx_range, !r_busy || (r_idx <= mcr_pkg::last_idx(r_kind)), "result index past end of run")
    `ASSERT_NEXT(a_end_result, emit_fire && (r_kind == mcr_pkg::KIND_END), o_out_valid && o_circle_done && o_last_of_run && !o_pixel_valid, "overshoot result malformed")
    `ASSERT_CLK(a_active_fall, !$fell(r_active) || $past(in_fire), "circle dropped without a command")
    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_pixel_address) && $stable(o_last_of_run), "stalled result changed")

endmodule
